// ===== sv/akxor_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package akxor_pkg;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_DECRYPT_MODE = 1'b0,
    REG_INITIAL_KEY  = 1'b1
  } cfg_reg_e;

  localparam logic [15:0] KEY_MUL   = 16'd52845;
  localparam logic [15:0] KEY_ADD   = 16'd11719;
  localparam logic [15:0] KEY_RESET = 16'd1234;
  localparam logic [7:0]  CHAR_BASE = 8'd64;

endpackage

`default_nettype wire

// ===== sv/autokey_xor_text_cipher_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Autokey XOR text cipher, one byte (or one character pair) per request.
// Input channel: in_valid_i / in_stall_o with first_char_i, second_char_i and
// message_start_i. A request is taken when valid is high and stall is low.
// Output channel: out_valid_o / out_stall_i with out_first_o, out_second_o
// and text_end_o. A request gives zero or one result.
// Configuration: cfg_valid_i / cfg_ready_o, cfg_index_i selects decrypt_mode
// (0) or initial_key (1); cfg_ready_o is always high. Write only while idle.
// A taken request passes through the input register and then the result
// register. Throughput is one request per cycle while the receiver does not
// stall; the 16-bit key update (add, constant multiply, add) sits in the
// single stage between those registers.
// When the receiver stalls, the result register holds and the input register
// fills; stall is then raised on the input side. A request that gives no
// result (text already ended) drains without touching the output.
// Reset clears both valid flags, the ended flag, sets mode to encrypt and
// loads 1234 into both the initial key and the running key.
module autokey_xor_text_cipher_unit
  import akxor_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  // input requests
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  first_char_i,
  input  wire logic [7:0]  second_char_i,
  input  wire logic        message_start_i,
  // results
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_first_o,
  output logic [7:0]       out_second_o,
  output logic             text_end_o
);

  logic        mode_q;
  logic [15:0] init_key_q;
  logic [15:0] key_q, key_d;
  logic        ended_q, ended_d;

  logic        a_valid_q, a_valid_d;
  logic [7:0]  a_first_q, a_second_q;
  logic        a_start_q;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_first_q, out_second_q;
  logic        text_end_q;

  logic        out_blocked, in_accept, a_fire;
  logic [15:0] key_cur, key_sum, key_prod, key_next;
  logic        ended_cur, produce, dec_end;
  logic [7:0]  khi, t_enc, t_dec, t_val, plain;
  logic [7:0]  res_first, res_second;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      init_key_q <= KEY_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_DECRYPT_MODE: mode_q     <= cfg_data_i[0];
        REG_INITIAL_KEY:  init_key_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake
  assign out_blocked = out_valid_q && out_stall_i;
  assign in_stall_o  = a_valid_q && out_blocked;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign a_fire      = a_valid_q && !out_blocked;

  // key step and coding
  always_comb begin
    key_cur   = a_start_q ? init_key_q : key_q;
    ended_cur = a_start_q ? 1'b0 : ended_q;
    khi       = key_cur[15:8];
    t_enc     = a_first_q ^ khi;
    t_dec     = a_first_q - CHAR_BASE + {a_second_q[3:0], 4'b0000};
    t_val     = mode_q ? t_dec : t_enc;
    plain     = t_dec ^ khi;
    produce   = !ended_cur;
    dec_end   = mode_q && (plain == 8'd0);
    key_sum   = {{8{t_val[7]}}, t_val} + key_cur;
    key_prod  = key_sum * KEY_MUL;
    key_next  = key_prod + KEY_ADD;
    if (mode_q) begin
      res_first  = plain;
      res_second = 8'd0;
    end else begin
      res_first  = CHAR_BASE + {4'b0000, t_enc[3:0]};
      res_second = CHAR_BASE + {4'b0000, t_enc[7:4]};
    end
  end

  always_comb begin
    key_d   = key_q;
    ended_d = ended_q;
    if (a_fire) begin
      ended_d = ended_cur || (produce && dec_end);
      if (!produce || dec_end) begin
        key_d = key_cur;
      end else begin
        key_d = key_next;
      end
    end
  end

  always_comb begin
    a_valid_d = a_valid_q;
    if (in_accept) begin
      a_valid_d = 1'b1;
    end else if (a_fire) begin
      a_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (a_fire) begin
      out_valid_d = produce;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q       <= KEY_RESET;
      ended_q     <= 1'b0;
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      key_q       <= key_d;
      ended_q     <= ended_d;
      a_valid_q   <= a_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_first_q  <= first_char_i;
      a_second_q <= second_char_i;
      a_start_q  <= message_start_i;
    end
    if (a_fire && produce) begin
      out_first_q  <= res_first;
      out_second_q <= res_second;
      text_end_q   <= dec_end;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_first_o  = out_first_q;
  assign out_second_o = out_second_q;
  assign text_end_o   = text_end_q;

  // input side only stalls with a result held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled without a held result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && text_end_o) |-> (out_first_o == 8'd0 && out_second_o == 8'd0))
    else $error("end of text result carries data");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_second_o != 8'd0) |-> (out_second_o[7:4] == 4'h4
      && out_first_o[7:4] == 4'h4 && !text_end_o))
    else $error("encrypted characters out of coding range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_fire && produce && dec_end) |=> ended_q)
    else $error("end of text not latched");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_fire && ended_q && !a_start_q) |=> (!out_valid_o && $stable(key_q)))
    else $error("request after end of text produced a result");

endmodule

`default_nettype wire

// ===== test/tb_autokey_xor_text_cipher_unit.sv =====
`timescale 1ns / 1ps

module tb_autokey_xor_text_cipher_unit
  import akxor_pkg::*;
;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 6;

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
    logic       fin;
  } char_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = REG_DECRYPT_MODE;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  first_char_i = '0;
  logic [7:0]  second_char_i = '0;
  logic        message_start_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  out_first_o;
  logic [7:0]  out_second_o;
  logic        text_end_o;

  // predictor state, mirrors the block
  logic        decrypt_on = 1'b0;
  logic [15:0] start_key = KEY_RESET;
  logic [15:0] live_key = KEY_RESET;
  logic        text_done = 1'b0;

  char_result_t pending_chars_q[$];
  int unsigned  mismatches = 0;
  int unsigned  cycles = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  logic         out_hold = 1'b0;

  autokey_xor_text_cipher_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .first_char_i   (first_char_i),
    .second_char_i  (second_char_i),
    .message_start_i(message_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_first_o    (out_first_o),
    .out_second_o   (out_second_o),
    .text_end_o     (text_end_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= out_hold || ($urandom_range(99) < recv_idle_pct);
  end

  function automatic logic [15:0] scramble_key(logic [15:0] key, logic [7:0] t);
    logic [15:0] ext;
    ext = {{8{t[7]}}, t};
    return (ext + key) * KEY_MUL + KEY_ADD;
  endfunction

  task automatic advance_cipher(input logic [7:0] fc, input logic [7:0] sc, input logic st);
    logic [7:0]   khi;
    logic [7:0]   t;
    logic [7:0]   plain;
    char_result_t r;
    if (st) begin
      live_key = start_key;
      text_done = 1'b0;
    end
    if (text_done) return;
    khi = live_key[15:8];
    if (!decrypt_on) begin
      t = fc ^ khi;
      r.first = {4'b0, t[3:0]} + CHAR_BASE;
      r.second = {4'b0, t[7:4]} + CHAR_BASE;
      r.fin = 1'b0;
      live_key = scramble_key(live_key, t);
    end else begin
      t = fc - CHAR_BASE + {sc[3:0], 4'b0};
      plain = t ^ khi;
      r.first = plain;
      r.second = 8'd0;
      r.fin = (plain == 8'd0);
      // end of text leaves the key where it was
      if (plain == 8'd0) text_done = 1'b1;
      else live_key = scramble_key(live_key, t);
    end
    pending_chars_q.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(negedge clk_i) begin : check_results
    char_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_chars_q.size() == 0) begin
        report_mismatch("unexpected result", int'(out_first_o), 0);
      end else begin
        want = pending_chars_q.pop_front();
        if (out_first_o !== want.first)
          report_mismatch("out_first", int'(out_first_o), int'(want.first));
        if (out_second_o !== want.second)
          report_mismatch("out_second", int'(out_second_o), int'(want.second));
        if (text_end_o !== want.fin)
          report_mismatch("text_end", int'(text_end_o), int'(want.fin));
      end
    end
  end

  // called and returns at a rising edge; the request is taken at the last edge
  task automatic send_request(input logic [7:0] fc, input logic [7:0] sc, input logic st);
    bit taken;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    first_char_i <= fc;
    second_char_i <= sc;
    message_start_i <= st;
    taken = 0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      if (taken) advance_cipher(fc, sc, st);
      @(posedge clk_i);
    end
  endtask

  // in decrypt mode, encodes a plain byte against the key the block will hold for it; in encrypt mode sends it as is
  task automatic send_plain(input logic [7:0] plain, input logic st);
    logic [7:0] t;
    if (!decrypt_on) begin
      send_request(plain, 8'($urandom_range(255)), st);
    end else begin
      t = plain ^ (st ? start_key[15:8] : live_key[15:8]);
      send_request({4'b0, t[3:0]} + CHAR_BASE, {4'b0, t[7:4]} + CHAR_BASE, st);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_chars_q.size() != 0) @(posedge clk_i);
    // a request with no result may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(input cfg_reg_e idx, input logic [15:0] data);
    bit done;
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    done = 0;
    while (!done) begin
      @(negedge clk_i);
      done = cfg_ready_o;
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    if (idx == REG_DECRYPT_MODE) decrypt_on = data[0];
    else start_key = data;
  endtask

  task automatic test_encrypt_directed();
    // reset key used without a start, then the byte extremes
    send_request(8'h00, 8'hFF, 1'b0);
    send_request(8'hFF, 8'h00, 1'b0);
    send_request(8'h80, 8'h55, 1'b1);
    send_request(8'h7F, 8'hAA, 1'b0);
    send_request(8'h41, 8'h00, 1'b0);
    drain_results();
    write_config(REG_INITIAL_KEY, 16'hFFFF);
    send_request(8'h00, 8'h00, 1'b1);
    send_request(8'hFF, 8'hFF, 1'b0);
    send_request(8'h80, 8'h80, 1'b0);
    drain_results();
  endtask

  task automatic test_decrypt_directed();
    write_config(REG_DECRYPT_MODE, 16'd1);
    write_config(REG_INITIAL_KEY, 16'h0000);
    send_plain(8'h48, 1'b1);
    send_plain(8'h69, 1'b0);
    send_plain(8'hFF, 1'b0);
    send_plain(8'h80, 1'b0);
    send_plain(8'h01, 1'b0);
    // characters outside the coding range
    send_request(8'h00, 8'hFF, 1'b0);
    send_request(8'hFF, 8'h0F, 1'b0);
    send_plain(8'h7F, 1'b1);
    send_plain(8'h00, 1'b0);
    // ended: nothing comes back until the next start
    send_request(8'h41, 8'h44, 1'b0);
    send_request(8'hFF, 8'hFF, 1'b0);
    drain_results();
    write_config(REG_DECRYPT_MODE, 16'd0);
    send_request(8'h12, 8'h34, 1'b0);
    send_plain(8'h5A, 1'b1);
    send_plain(8'h00, 1'b0);
    drain_results();
  endtask

  task automatic test_random_traffic(input int n_items, input int s_pct, input int r_pct);
    int sent;
    int len;
    int kind;
    int i;
    logic [15:0] key;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(3) == 0) begin
        drain_results();
        write_config(REG_DECRYPT_MODE, 16'($urandom_range(1)));
        case ($urandom_range(3))
          0: key = 16'h0000;
          1: key = 16'hFFFF;
          default: key = 16'($urandom_range(16'hFFFF));
        endcase
        write_config(REG_INITIAL_KEY, key);
      end
      len = $urandom_range(1, 12);
      kind = $urandom_range(99);
      for (i = 0; i < len; i++) begin
        if (kind < 15) begin
          send_request(8'($urandom_range(255)), 8'($urandom_range(255)),
                       $urandom_range(7) == 0);
        end else if (!decrypt_on) begin
          send_plain(8'($urandom_range(255)), i == 0);
        end else if (i == len - 1 && $urandom_range(1) == 1) begin
          send_plain(8'h00, i == 0);
          // ignored tail after end of text
          repeat ($urandom_range(2))
            send_request(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0);
        end else begin
          send_plain(8'($urandom_range(1, 255)), i == 0);
        end
      end
      sent += len;
    end
    drain_results();
  endtask

  task automatic test_backpressure();
    int i;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      begin
        repeat (80) begin
          out_hold <= 1'b1;
          @(posedge clk_i);
        end
        out_hold <= 1'b0;
      end
    join_none
    for (i = 0; i < 24; i++) send_plain(8'($urandom_range(1, 255)), i == 0);
    // pause mid-message until everything is back, then carry on
    drain_results();
    for (i = 0; i < 10; i++) send_plain(8'($urandom_range(1, 255)), 1'b0);
    drain_results();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 13;
    recv_idle_pct = 47;
    test_encrypt_directed();
    test_decrypt_directed();
    test_random_traffic(130, 13, 47);
    test_random_traffic(130, 47, 13);
    test_backpressure();
    test_random_traffic(110, 0, 0);
    drain_results();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== autokey_xor_text_cipher_unit.f =====
sv/akxor_pkg.sv
sv/autokey_xor_text_cipher_unit.sv
test/tb_autokey_xor_text_cipher_unit.sv
